/* rtl/tmbc_pkg.sv */
`default_nettype none
package tmbc_pkg;

  // Fixed point: 8 fraction bits on every position.
  localparam int FX_BITS = 8;
  localparam int POS_W   = 24;
  localparam int POS_MAX = (2 ** (POS_W - 1)) - 1;
  localparam int POS_MIN = -(2 ** (POS_W - 1));

  // Working widths, sized for the widest parameter ranges.
  localparam int ACC_W  = 28;
  localparam int DIST_W = 30;

  localparam int TILE_IDX_W = 7;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int CFG_REG_W  = 8;

  localparam int TILE_SIZE_DEF   = 64;
  localparam int BOX_SIZE_DEF    = 60;
  localparam int BOX_HALF_DEF    = 30;
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 128;

  localparam logic [CFG_REG_W-1:0] MAP_SIZE_RESET = 8'd128;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  // Register select is paddr bit 2.
  localparam logic REG_MAP_COLUMNS = 1'b0;
  localparam logic REG_MAP_ROWS    = 1'b1;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [DIST_W-1:0] dist_t;

endpackage
`default_nettype wire

/* rtl/tmbc_tile_mem.sv */
`default_nettype none
module tmbc_tile_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  output logic          clr_busy
);

  logic          mem_r [DEPTH];
  logic          rd_data_r;
  logic [AW-1:0] clr_addr_r;
  logic          clr_active_r;

  // Sweep every entry to empty after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      clr_active_r <= 1'b1;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem_r[clr_addr_r] <= 1'b0;
    end else if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_active_r;

endmodule
`default_nettype wire

/* rtl/tmbc_push.sv */
`default_nettype none
module tmbc_push #(
  parameter int TILE_SIZE = 64,
  parameter int BOX_HALF  = 30,
  parameter int COL_W     = 7,
  parameter int ROW_W     = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [COL_W-1:0]     col,
  input  logic [ROW_W-1:0]     row,
  input  tmbc_pkg::acc_t       px_i,
  input  tmbc_pkg::acc_t       py_i,
  output logic                 done,
  output tmbc_pkg::acc_t       px_o,
  output tmbc_pkg::acc_t       py_o
);
  import tmbc_pkg::*;

  localparam int SH       = $clog2(TILE_SIZE) + FX_BITS;
  localparam int HALF_FX  = BOX_HALF * (2 ** FX_BITS);
  localparam int TILE_HFX = TILE_SIZE * (2 ** (FX_BITS - 1));
  localparam int MIN_DIST = HALF_FX + TILE_HFX;
  localparam int CTR_OFS  = HALF_FX - TILE_HFX;

  logic  v1_r, v2_r, done_r;
  dist_t dx_r, dy_r, xd_r, yd_r;
  logic  xneg_r, yneg_r;
  acc_t  px_r, py_r, px_o_r, py_o_r;
  logic  overlap, push_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  // Push along the shallower axis; a tie goes to y.
  assign overlap = (xd_r > dist_t'(0)) && (yd_r > dist_t'(0));
  assign push_x  = xd_r < yd_r;

  always_ff @(posedge clk) begin
    // Center distances from box center to tile center.
    if (start) begin
      px_r <= px_i;
      py_r <= py_i;
      dx_r <= dist_t'(px_i) + dist_t'(CTR_OFS) - (dist_t'(col) <<< SH);
      dy_r <= dist_t'(py_i) + dist_t'(CTR_OFS) - (dist_t'(row) <<< SH);
    end
    // Overlap depth on each axis.
    if (v1_r) begin
      xneg_r <= dx_r[DIST_W-1];
      yneg_r <= dy_r[DIST_W-1];
      xd_r   <= dx_r[DIST_W-1] ? dist_t'(MIN_DIST) + dx_r : dist_t'(MIN_DIST) - dx_r;
      yd_r   <= dy_r[DIST_W-1] ? dist_t'(MIN_DIST) + dy_r : dist_t'(MIN_DIST) - dy_r;
    end
    if (v2_r) begin
      if (overlap && push_x) begin
        px_o_r <= xneg_r ? acc_t'(dist_t'(px_r) - xd_r) : acc_t'(dist_t'(px_r) + xd_r);
      end else begin
        px_o_r <= px_r;
      end
      if (overlap && !push_x) begin
        py_o_r <= yneg_r ? acc_t'(dist_t'(py_r) - yd_r) : acc_t'(dist_t'(py_r) + yd_r);
      end else begin
        py_o_r <= py_r;
      end
    end
  end

  assign done = done_r;
  assign px_o = px_o_r;
  assign py_o = py_o_r;

endmodule
`default_nettype wire

/* rtl/tile_map_box_collision.sv */
// Channel   Direction  Handshake           Payload
// in_       request    in_valid/in_ready   cmd, tile_column, tile_row, tile_solid, box_x, box_y
// out_      result     out_valid/out_ready resolved_x, resolved_y, hit
// cfg (APB) write/read psel/penable/pready paddr, pwdata, prdata (map_columns, map_rows)
//
// A tile write goes into the map as it is accepted. A resolve does four reads from the
// single map port, then one three-stage push per corner on a solid tile, applied
// in corner order.
// After reset a clearing pass empties the map, one tile a cycle, over all MAX_ROWS*MAX_COLUMNS
// tiles (16384 by default); in_ready stays low until it ends.
// A finished result waits in the output register; the next request is taken meanwhile.
`default_nettype none
module tile_map_box_collision #(
  parameter int TILE_SIZE   = tmbc_pkg::TILE_SIZE_DEF,
  parameter int BOX_SIZE    = tmbc_pkg::BOX_SIZE_DEF,
  parameter int BOX_HALF    = tmbc_pkg::BOX_HALF_DEF,
  parameter int MAX_COLUMNS = tmbc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tmbc_pkg::MAX_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic [tmbc_pkg::TILE_IDX_W-1:0]      in_tile_column,
  input  logic [tmbc_pkg::TILE_IDX_W-1:0]      in_tile_row,
  input  logic                                 in_tile_solid,
  input  logic signed [tmbc_pkg::POS_W-1:0]    in_box_x,
  input  logic signed [tmbc_pkg::POS_W-1:0]    in_box_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tmbc_pkg::POS_W-1:0]    out_resolved_x,
  output logic signed [tmbc_pkg::POS_W-1:0]    out_resolved_y,
  output logic                                 out_hit,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tmbc_pkg::CFG_AW-1:0]          paddr,
  input  logic [tmbc_pkg::CFG_DW-1:0]          pwdata,
  output logic [tmbc_pkg::CFG_DW-1:0]          prdata,
  output logic                                 pready
);
  import tmbc_pkg::*;

  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SH     = $clog2(TILE_SIZE) + FX_BITS;
  localparam int BOX_FX = BOX_SIZE * (2 ** FX_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TILE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  function automatic logic [AW-1:0] tile_addr(input logic [31:0] r, input logic [31:0] c);
    logic [31:0] a;
    a = r * MAX_COLUMNS + c;
    return a[AW-1:0];
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input acc_t v);
    if (v > acc_t'(POS_MAX)) begin
      return POS_W'(POS_MAX);
    end else if (v < acc_t'(POS_MIN)) begin
      return POS_W'(POS_MIN);
    end
    return v[POS_W-1:0];
  endfunction

  // Configuration registers.
  logic [CFG_REG_W-1:0] map_columns_r, map_rows_r;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_columns_r <= MAP_SIZE_RESET;
      map_rows_r    <= MAP_SIZE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAP_COLUMNS) begin
        map_columns_r <= pwdata[CFG_REG_W-1:0];
      end else begin
        map_rows_r <= pwdata[CFG_REG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MAP_ROWS) ? CFG_DW'(map_rows_r) : CFG_DW'(map_columns_r);

  // Sequencer state.
  logic [2:0]       state_r, state_nxt;
  logic [1:0]       k_r;
  acc_t             x0_r, y0_r, px_r, py_r;
  logic [COL_W-1:0] col0_r, col1_r;
  logic [ROW_W-1:0] row0_r, row1_r;
  logic [1:0]       colok_r, rowok_r;
  logic [3:0]       solid_r;
  logic             hit_r;
  logic             rd_pend_r;
  logic [1:0]       rd_idx_r;

  logic             out_valid_r, out_hit_r;
  logic [POS_W-1:0] out_x_r, out_y_r;

  logic             clr_busy, rd_data, in_acc, wr_en, out_load;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [1:0]       pick_idx;
  logic             push_start, push_done;
  acc_t             push_px, push_py;

  // Corner tiles, from the original position.
  logic [CFG_REG_W-1:0] cols_use, rows_use;
  acc_t                 cx1, cy1;
  logic [ACC_W-1:0]     tc0, tc1, tr0, tr1;
  logic [3:0]           corner_ok;

  assign cols_use = (32'(map_columns_r) > MAX_COLUMNS) ? CFG_REG_W'(MAX_COLUMNS) : map_columns_r;
  assign rows_use = (32'(map_rows_r) > MAX_ROWS) ? CFG_REG_W'(MAX_ROWS) : map_rows_r;
  assign cx1 = x0_r + acc_t'(BOX_FX);
  assign cy1 = y0_r + acc_t'(BOX_FX);
  assign tc0 = x0_r >>> SH;
  assign tc1 = cx1 >>> SH;
  assign tr0 = y0_r >>> SH;
  assign tr1 = cy1 >>> SH;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      corner_ok[k] = colok_r[k % 2] && rowok_r[k / 2];
    end
  end

  assign in_ready = (state_r == S_IDLE) && !clr_busy;
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = in_acc && (in_cmd == CMD_WRITE) &&
                    (32'(in_tile_column) < MAX_COLUMNS) && (32'(in_tile_row) < MAX_ROWS);
  assign wr_addr  = tile_addr(32'(in_tile_row), 32'(in_tile_column));
  assign rd_addr  = tile_addr(32'(k_r[1] ? row1_r : row0_r), 32'(k_r[0] ? col1_r : col0_r));
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Lowest pending solid corner goes first.
  always_comb begin
    priority if (solid_r[0]) begin
      pick_idx = 2'd0;
    end else if (solid_r[1]) begin
      pick_idx = 2'd1;
    end else if (solid_r[2]) begin
      pick_idx = 2'd2;
    end else begin
      pick_idx = 2'd3;
    end
  end

  assign push_start = (state_r == S_PICK) && (solid_r != 4'd0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && in_cmd == CMD_RESOLVE) begin
        state_nxt = S_TILE;
      end
      S_TILE: state_nxt = S_READ;
      S_READ: if (k_r == 2'd3) begin
        state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_PICK;
      S_PICK: state_nxt = (solid_r == 4'd0) ? S_DONE : S_PUSH;
      S_PUSH: if (push_done) begin
        state_nxt = S_PICK;
      end
      S_DONE: if (out_load) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == S_READ);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= k_r;
    // Latch the request and start from the original position.
    if (in_acc && in_cmd == CMD_RESOLVE) begin
      x0_r    <= acc_t'(in_box_x);
      y0_r    <= acc_t'(in_box_y);
      px_r    <= acc_t'(in_box_x);
      py_r    <= acc_t'(in_box_y);
      solid_r <= 4'd0;
      hit_r   <= 1'b0;
      k_r     <= 2'd0;
    end
    if (state_r == S_TILE) begin
      col0_r     <= tc0[COL_W-1:0];
      col1_r     <= tc1[COL_W-1:0];
      row0_r     <= tr0[ROW_W-1:0];
      row1_r     <= tr1[ROW_W-1:0];
      colok_r[0] <= !tc0[ACC_W-1] && (tc0 < ACC_W'(cols_use));
      colok_r[1] <= !tc1[ACC_W-1] && (tc1 < ACC_W'(cols_use));
      rowok_r[0] <= !tr0[ACC_W-1] && (tr0 < ACC_W'(rows_use));
      rowok_r[1] <= !tr1[ACC_W-1] && (tr1 < ACC_W'(rows_use));
    end
    if (state_r == S_READ) begin
      k_r <= k_r + 2'd1;
    end
    // Drop corners off the map; keep solid ones.
    if (rd_pend_r) begin
      solid_r[rd_idx_r] <= rd_data && corner_ok[rd_idx_r];
    end
    if (state_r == S_PICK) begin
      hit_r <= hit_r || (solid_r != 4'd0);
      if (push_start) begin
        solid_r[pick_idx] <= 1'b0;
      end
    end
    if (state_r == S_PUSH && push_done) begin
      px_r <= push_px;
      py_r <= push_py;
    end
    if (out_load) begin
      out_x_r   <= sat_pos(px_r);
      out_y_r   <= sat_pos(py_r);
      out_hit_r <= hit_r;
    end
  end

  tmbc_tile_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (in_tile_solid),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  tmbc_push #(
    .TILE_SIZE (TILE_SIZE),
    .BOX_HALF  (BOX_HALF),
    .COL_W     (COL_W),
    .ROW_W     (ROW_W)
  ) u_push (
    .clk   (clk),
    .rst_n (rst_n),
    .start (push_start),
    .col   (pick_idx[0] ? col1_r : col0_r),
    .row   (pick_idx[1] ? row1_r : row0_r),
    .px_i  (px_r),
    .py_i  (py_r),
    .done  (push_done),
    .px_o  (push_px),
    .py_o  (push_py)
  );

  assign out_valid      = out_valid_r;
  assign out_resolved_x = out_x_r;
  assign out_resolved_y = out_y_r;
  assign out_hit        = out_hit_r;

`ifndef SYNTH
  a_resolve_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_RESOLVE) |=> (state_r == S_TILE))
    else $error("resolve request did not start the corner lookup");

  a_push_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && push_done) |=> (state_r == S_PICK))
    else $error("push finished without returning to corner pick");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared outside the done step");

  a_no_hit_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !hit_r) |-> (px_r == x0_r && py_r == y0_r))
    else $error("position moved without a solid corner");

  a_no_request_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready)
    else $error("request taken during map clear");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tmbc_pkg::*;

  // Fixed-point geometry of the default build, in 1/256 pixel units.
  localparam longint TILE_FX   = longint'(TILE_SIZE_DEF) * (1 << FX_BITS);
  localparam int     TILE_SHIFT = $clog2(TILE_SIZE_DEF) + FX_BITS;
  localparam longint BOX_FX    = longint'(BOX_SIZE_DEF) * (1 << FX_BITS);
  localparam longint HALF_FX   = longint'(BOX_HALF_DEF) * (1 << FX_BITS);
  localparam longint REACH_FX  = HALF_FX + TILE_FX / 2;
  localparam int     T         = TILE_SIZE_DEF * (1 << FX_BITS);

  // Settle time after draining, longer than the worst resolve.
  localparam int SETTLE_CYCLES = 30;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_REQS    = 305;

  typedef struct {
    logic                    cmd;
    logic [TILE_IDX_W-1:0]   column;
    logic [TILE_IDX_W-1:0]   row;
    logic                    solid;
    logic signed [POS_W-1:0] box_x;
    logic signed [POS_W-1:0] box_y;
  } tile_req_t;

  typedef struct {
    logic signed [POS_W-1:0] resolved_x;
    logic signed [POS_W-1:0] resolved_y;
    logic                    hit;
  } box_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_cmd = CMD_WRITE;
  logic [TILE_IDX_W-1:0]   in_tile_column = '0;
  logic [TILE_IDX_W-1:0]   in_tile_row = '0;
  logic                    in_tile_solid = 1'b0;
  logic signed [POS_W-1:0] in_box_x = '0;
  logic signed [POS_W-1:0] in_box_y = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] out_resolved_x;
  logic signed [POS_W-1:0] out_resolved_y;
  logic                    out_hit;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CFG_AW-1:0]       paddr = '0;
  logic [CFG_DW-1:0]       pwdata = '0;
  logic [CFG_DW-1:0]       prdata;
  logic                    pready;

  // Shadow copy of the block's state: tile map and both size registers.
  bit                   tile_solid_map [MAX_ROWS_DEF * MAX_COLUMNS_DEF];
  logic [CFG_REG_W-1:0] cols_reg = MAP_SIZE_RESET;
  logic [CFG_REG_W-1:0] rows_reg = MAP_SIZE_RESET;

  tile_req_t   pending_reqs[$];
  box_result_t expected_boxes[$];
  tile_req_t   offered;

  int   error_count = 0;
  int   accepted_reqs = 0;
  int   tx_gap = 0;
  int   rx_stall = 0;
  int   tx_idle_pct = 30;
  int   rx_idle_pct = 30;
  logic quiet = 1'b0;
  logic rx_hold = 1'b0;

  // Register settings per phase, extremes included: above the map size, one tile, zero.
  int phase_cols [NUM_PHASES] = '{128, 255, 1, 0, 128, 37};
  int phase_rows [NUM_PHASES] = '{128, 200, 1, 9, 0, 90};
  int phase_tx   [NUM_PHASES] = '{30, 0, 50, 15, 20, 0};
  int phase_rx   [NUM_PHASES] = '{30, 40, 0, 50, 20, 0};

  tile_map_box_collision DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_tile_column (in_tile_column),
    .in_tile_row    (in_tile_row),
    .in_tile_solid  (in_tile_solid),
    .in_box_x       (in_box_x),
    .in_box_y       (in_box_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_resolved_x (out_resolved_x),
    .out_resolved_y (out_resolved_y),
    .out_hit        (out_hit),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Saturate a wide position back to the 24-bit output range.
  function automatic logic signed [POS_W-1:0] clamp24(input longint v);
    longint c;
    c = v;
    if (c > POS_MAX) c = POS_MAX;
    if (c < POS_MIN) c = POS_MIN;
    return c[POS_W-1:0];
  endfunction

  // Resolve one box against the shadow map: corners from the original position,
  // then one push per solid corner in order top-left, top-right, bottom-left,
  // bottom-right, along the axis of smaller overlap (tie goes to y).
  function automatic box_result_t resolve_box(input logic signed [POS_W-1:0] bx,
                                               input logic signed [POS_W-1:0] by);
    longint x0, y0, px, py, cx, cy, col, row, dx, dy, xd, yd, ncols, nrows;
    box_result_t r;
    x0 = bx;
    y0 = by;
    px = x0;
    py = y0;
    ncols = (cols_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cols_reg;
    nrows = (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_reg;
    r.hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      cx = x0 + (k[0] ? BOX_FX : 0);
      cy = y0 + (k[1] ? BOX_FX : 0);
      // Floor division by the tile size: arithmetic shift of a signed value.
      col = cx >>> TILE_SHIFT;
      row = cy >>> TILE_SHIFT;
      // Skip corners off the map in use and corners on empty tiles.
      if (col >= 0 && col < ncols && row >= 0 && row < nrows &&
          tile_solid_map[row * MAX_COLUMNS_DEF + col]) begin
        r.hit = 1'b1;
        dx = px + HALF_FX - (col * TILE_FX + TILE_FX / 2);
        dy = py + HALF_FX - (row * TILE_FX + TILE_FX / 2);
        xd = REACH_FX - (dx < 0 ? -dx : dx);
        yd = REACH_FX - (dy < 0 ? -dy : dy);
        // Solid but not overlapping any more: hit stays, position holds.
        if (xd > 0 && yd > 0) begin
          // Aligned centers (zero distance) push in the positive direction.
          if (xd < yd) px = (dx < 0) ? px - xd : px + xd;
          else py = (dy < 0) ? py - yd : py + yd;
        end
      end
    end
    r.resolved_x = clamp24(px);
    r.resolved_y = clamp24(py);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  function automatic void push_write(input int col, input int row, input logic solid);
    tile_req_t req;
    req.cmd    = CMD_WRITE;
    req.column = col[TILE_IDX_W-1:0];
    req.row    = row[TILE_IDX_W-1:0];
    req.solid  = solid;
    req.box_x  = POS_W'($urandom);
    req.box_y  = POS_W'($urandom);
    pending_reqs = {pending_reqs, req};
  endfunction

  function automatic void push_resolve(input int x, input int y);
    tile_req_t req;
    req.cmd    = CMD_RESOLVE;
    req.column = TILE_IDX_W'($urandom);
    req.row    = TILE_IDX_W'($urandom);
    req.solid  = 1'($urandom);
    req.box_x  = x[POS_W-1:0];
    req.box_y  = y[POS_W-1:0];
    pending_reqs = {pending_reqs, req};
  endfunction

  // Pick a tile index: mostly near the origin or near the edge of the map in use.
  function automatic int rand_tile(input int lim);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return int'($urandom_range(0, 5)) - 1;
    if (pick < 8) return lim - 3 + int'($urandom_range(0, 4));
    return int'($urandom_range(0, 127));
  endfunction

  // Box edge position: mostly on tiles that matter, sometimes anywhere in range.
  function automatic int rand_pos(input int lim);
    int v;
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 32'hFFFFFF));
    v = rand_tile(lim) * T + int'($urandom_range(0, T - 1));
    // Snap to a 2-pixel grid now and then to hit aligned centers and depth ties.
    if ($urandom_range(0, 3) == 0) v = v & -512;
    return v;
  endfunction

  // Write one size register, then read it back in the next transfer.
  task automatic write_map_reg(input logic sel, input logic [CFG_REG_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({sel, 2'b00});
    pwdata  <= CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // Write lands at this edge; keep psel high and go straight into the read setup.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_MAP_COLUMNS) cols_reg = val;
    else rows_reg = val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata[CFG_REG_W-1:0] !== val)
      flag_error($sformatf("register readback sel %0d: expected %0d got %0d",
                           sel, val, prdata[CFG_REG_W-1:0]));
  endtask

  // Hold until every queued request is taken and every result is back.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_boxes.size() != 0)
      @(posedge clk);
  endtask

  // Request driver: advance on acceptance, insert idle bursts, predict on the way in.
  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accepted_reqs++;
        if (offered.cmd == CMD_WRITE)
          tile_solid_map[offered.row * MAX_COLUMNS_DEF + offered.column] = offered.solid;
        else
          expected_boxes = {expected_boxes, resolve_box(offered.box_x, offered.box_y)};
      end
      // Hold the current request until it is taken; only then load the next one.
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
          tx_gap = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else begin
          offered = pending_reqs.pop_front();
          in_valid       <= 1'b1;
          in_cmd         <= offered.cmd;
          in_tile_column <= offered.column;
          in_tile_row    <= offered.row;
          in_tile_solid  <= offered.solid;
          in_box_x       <= offered.box_x;
          in_box_y       <= offered.box_y;
        end
      end
    end
  end

  // Result monitor: compare against the oldest expectation, then drive out_ready.
  always @(posedge clk) begin : check_results
    box_result_t want;
    logic        rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_boxes.size() == 0) begin
          flag_error($sformatf("result with nothing expected: x %0d y %0d hit %0d",
                               out_resolved_x, out_resolved_y, out_hit));
        end else begin
          want = expected_boxes.pop_front();
          if (out_resolved_x !== want.resolved_x || out_resolved_y !== want.resolved_y ||
              out_hit !== want.hit)
            flag_error($sformatf("mismatch: expected x %0d y %0d hit %0d, got x %0d y %0d hit %0d",
                                 want.resolved_x, want.resolved_y, want.hit,
                                 out_resolved_x, out_resolved_y, out_hit));
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
        rx_stall = $urandom_range(0, 9);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy && !rx_hold;
    end
  end

  // Long receiver hold-off early in the run: the sender keeps offering requests,
  // so the block fills up and drops in_ready.
  initial begin : long_holdoff
    while (accepted_reqs < 120) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (600) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : run_phases
    int lc, lr;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_map_reg(REG_MAP_COLUMNS, CFG_REG_W'(phase_cols[0]));
    write_map_reg(REG_MAP_ROWS, CFG_REG_W'(phase_rows[0]));

    // Directed requests on the full map.
    push_resolve(0, 0);                       // empty map, no hit
    push_write(0, 0, 1'b1);
    push_write(1, 0, 1'b1);
    push_write(0, 1, 1'b1);
    push_write(127, 127, 1'b1);
    push_write(127, 0, 1'b1);
    push_resolve(0, 0);                       // all four corners on one solid tile
    push_resolve(512, 512);                   // centers aligned, depth tie
    push_resolve(-2560, 0);                   // left corners off the map
    push_resolve(POS_MIN, POS_MIN);
    push_resolve(POS_MAX, POS_MAX);
    push_resolve(POS_MIN, POS_MAX);
    push_resolve(POS_MAX, POS_MIN);
    push_resolve(127 * T + 100, 127 * T + 100);  // far corner tile
    push_resolve(127 * T + 4000, 0);          // right corners past the last column
    push_write(0, 0, 1'b0);
    push_resolve(1024, 0);                    // touching a solid tile: hit, no push
    push_resolve(T - 7680, 768);
    push_write(1, 1, 1'b1);
    push_resolve(T / 2, T / 2);               // corners on different solid tiles
    push_write(127, 127, 1'b0);
    push_resolve(127 * T + 100, 127 * T + 100);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        // Let the block drain before touching the size registers.
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_map_reg(REG_MAP_COLUMNS, CFG_REG_W'(phase_cols[p]));
        write_map_reg(REG_MAP_ROWS, CFG_REG_W'(phase_rows[p]));
      end
      tx_idle_pct <= phase_tx[p];
      rx_idle_pct <= phase_rx[p];
      quiet       <= (p == NUM_PHASES - 1);
      lc = (phase_cols[p] > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : phase_cols[p];
      lr = (phase_rows[p] > MAX_ROWS_DEF) ? MAX_ROWS_DEF : phase_rows[p];
      for (int i = 0; i < PHASE_REQS; i++) begin
        if ($urandom_range(0, 3) == 0)
          push_write(rand_tile(lc), rand_tile(lr), $urandom_range(0, 99) < 65);
        else
          push_resolve(rand_pos(lc), rand_pos(lr));
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run, clearing pass included.
  initial begin : watchdog
    #18000000;
    $display("tb: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/tmbc_pkg.sv
rtl/tmbc_tile_mem.sv
rtl/tmbc_push.sv
rtl/tile_map_box_collision.sv
tb/sv/tb.sv
